// File: sv/ctcc_pkg.sv
package ctcc_pkg;

   localparam int HISTORY_DEPTH = 16;
   localparam int TAG_BITS      = 48;
   localparam int CHAN_BITS     = 3;
   localparam int OFFSET_BITS   = 41;
   localparam int WINDOW_BITS   = 40;
   localparam int TOTAL_BITS    = 32;
   localparam int MATCH_BITS    = 5;
   localparam int COUNT_BITS    = $clog2(HISTORY_DEPTH + 1);
   localparam int SPAN_BITS     = OFFSET_BITS + 1;
   localparam int BOUND_BITS    = TAG_BITS + 2;
   localparam int CSR_IDX_BITS  = 2;

   localparam logic [CHAN_BITS-1:0] MAX_CHANNEL = 3'd4;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CHAN_A = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHAN_B = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OFFSET = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW = 2'd3;

   localparam logic [CHAN_BITS-1:0]   CHAN_A_RESET = 3'd0;
   localparam logic [CHAN_BITS-1:0]   CHAN_B_RESET = 3'd1;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 40'd1000;

   typedef struct packed {
      logic [TAG_BITS-1:0] a_tag;
      logic                a_ok;
      logic [TAG_BITS-1:0] b_tag;
      logic                b_ok;
   } slot_type;

   typedef struct packed {
      logic                  live;
      logic [COUNT_BITS-1:0] count;
   } token_type;

   typedef struct packed {
      logic                         use_a;
      logic signed [BOUND_BITS-1:0] lo_bound;
      logic signed [BOUND_BITS-1:0] hi_bound;
   } probe_type;

   typedef struct packed {
      logic clear;
      logic shift_a;
      logic shift_b;
   } shift_ctl_type;

endpackage

// File: sv/ctcc_cell.sv
module ctcc_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  ctcc_pkg::slot_type      slot_in,
   output ctcc_pkg::slot_type      slot_out,
   input  ctcc_pkg::shift_ctl_type ctl,
   input  ctcc_pkg::probe_type     probe,
   input  ctcc_pkg::token_type     tok_in,
   output ctcc_pkg::token_type     tok_out
);

   ctcc_pkg::slot_type  slot_ff;
   ctcc_pkg::token_type tok_ff;

   logic [ctcc_pkg::TAG_BITS-1:0]          stored;
   logic                                   stored_ok;
   logic signed [ctcc_pkg::BOUND_BITS-1:0] stored_ext;
   logic                                   match;
   logic [ctcc_pkg::COUNT_BITS-1:0]        count_in;

   // the probe looks at the other channel's entry
   assign stored     = probe.use_a ? slot_ff.b_tag : slot_ff.a_tag;
   assign stored_ok  = probe.use_a ? slot_ff.b_ok : slot_ff.a_ok;
   assign stored_ext = $signed({2'b00, stored});
   assign match      = tok_in.live && stored_ok &&
                       (stored_ext > probe.lo_bound) && (stored_ext < probe.hi_bound);
   assign count_in   = tok_in.count + ctcc_pkg::COUNT_BITS'(match);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.a_ok <= 1'b0;
         slot_ff.b_ok <= 1'b0;
         tok_ff.live  <= 1'b0;
      end else begin
         if (ctl.clear) begin
            slot_ff.a_ok <= 1'b0;
            slot_ff.b_ok <= 1'b0;
         end else begin
            if (ctl.shift_a) begin
               slot_ff.a_tag <= slot_in.a_tag;
               slot_ff.a_ok  <= slot_in.a_ok;
            end
            if (ctl.shift_b) begin
               slot_ff.b_tag <= slot_in.b_tag;
               slot_ff.b_ok  <= slot_in.b_ok;
            end
         end
         tok_ff.live <= tok_in.live;
      end
      tok_ff.count <= count_in;
   end

   assign slot_out = slot_ff;
   assign tok_out  = tok_ff;

endmodule

// File: sv/two_channel_coincidence_counter.sv
// one request at a time: a request is taken only in IDLE, and the response is registered after
// the BOUNDS, BASE, SWEEP and FINISH states, with the next request taken once back in IDLE
// SWEEP lasts while a match token walks the 16-cell history chain, one cell a cycle
// a waiting response does not block the next request; it only holds the final step
// synchronous active-high reset clears histories, running total, handshake state and
// restores the register defaults
module two_channel_coincidence_counter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [47:0]                         req_tdata,   // tag_time
   input  logic [3:0]                          req_tuser,   // chan_num, first_of_block
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [39:0]                         rsp_tdata,   // matches_here, total_count, pad
   output logic [0:0]                          rsp_tuser,   // history_overrun
   input  logic                                csr_wen,
   input  logic [ctcc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [ctcc_pkg::OFFSET_BITS-1:0]    csr_wdata
);

   localparam int D = ctcc_pkg::HISTORY_DEPTH;

   typedef enum logic [2:0] {IDLE, BOUNDS, BASE, SWEEP, FINISH} state_type;

   state_type state_ff;

   logic [ctcc_pkg::CHAN_BITS-1:0]   chan_a_ff;
   logic [ctcc_pkg::CHAN_BITS-1:0]   chan_b_ff;
   logic [ctcc_pkg::OFFSET_BITS-1:0] offset_ff;
   logic [ctcc_pkg::WINDOW_BITS-1:0] window_ff;

   logic [ctcc_pkg::TAG_BITS-1:0]          tag_ff;
   logic                                   hit_ff;
   logic                                   use_a_ff;
   logic signed [ctcc_pkg::SPAN_BITS-1:0]  lo_ff;
   logic signed [ctcc_pkg::SPAN_BITS-1:0]  hi_ff;
   logic signed [ctcc_pkg::SPAN_BITS-1:0]  reach_ff;
   logic                                   window_nz_ff;
   logic                                   overrun_ff;
   logic [ctcc_pkg::COUNT_BITS-1:0]        count_ff;
   logic [ctcc_pkg::TOTAL_BITS-1:0]        total_ff;
   ctcc_pkg::probe_type                    probe_ff;
   ctcc_pkg::token_type                    start_tok_ff;

   logic                                   rsp_valid_ff;
   logic [ctcc_pkg::MATCH_BITS-1:0]        rsp_matches_ff;
   logic [ctcc_pkg::TOTAL_BITS-1:0]        rsp_total_ff;
   logic                                   rsp_overrun_ff;

   ctcc_pkg::slot_type      links [D+1];
   ctcc_pkg::token_type     toks  [D+1];
   ctcc_pkg::shift_ctl_type ctl;

   logic [ctcc_pkg::TAG_BITS-1:0]          req_tag;
   logic [ctcc_pkg::CHAN_BITS-1:0]         req_chan;
   logic                                   req_first;
   logic                                   accept;
   logic                                   out_free;

   logic signed [ctcc_pkg::SPAN_BITS-1:0]  offset_ext;
   logic signed [ctcc_pkg::SPAN_BITS-1:0]  window_ext;
   logic signed [ctcc_pkg::SPAN_BITS-1:0]  lo_in;
   logic signed [ctcc_pkg::SPAN_BITS-1:0]  hi_in;

   logic signed [ctcc_pkg::BOUND_BITS-1:0] t_ext;
   logic signed [ctcc_pkg::BOUND_BITS-1:0] lo_wide;
   logic signed [ctcc_pkg::BOUND_BITS-1:0] hi_wide;
   logic [ctcc_pkg::TAG_BITS-1:0]          tail_tag;
   logic                                   tail_ok;
   logic signed [ctcc_pkg::BOUND_BITS-1:0] age;
   logic                                   overrun_in;

   logic [ctcc_pkg::TOTAL_BITS:0]          sum_in;
   logic [ctcc_pkg::TOTAL_BITS-1:0]        total_in;

   assign req_tag    = req_tdata[ctcc_pkg::TAG_BITS-1:0];
   assign req_chan   = req_tuser[ctcc_pkg::CHAN_BITS-1:0];
   assign req_first  = req_tuser[ctcc_pkg::CHAN_BITS];
   assign req_tready = (state_ff == IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign offset_ext = $signed({offset_ff[ctcc_pkg::OFFSET_BITS-1], offset_ff});
   assign window_ext = $signed({2'b00, window_ff});
   assign lo_in      = offset_ext - window_ext;
   assign hi_in      = offset_ext + window_ext;

   assign t_ext    = $signed({2'b00, tag_ff});
   assign lo_wide  = ctcc_pkg::BOUND_BITS'(lo_ff);
   assign hi_wide  = ctcc_pkg::BOUND_BITS'(hi_ff);
   assign tail_tag = use_a_ff ? links[D].a_tag : links[D].b_tag;
   assign tail_ok  = use_a_ff ? links[D].a_ok : links[D].b_ok;
   assign age      = t_ext - $signed({2'b00, tail_tag});
   assign overrun_in = hit_ff && tail_ok && window_nz_ff &&
                       (age < ctcc_pkg::BOUND_BITS'(reach_ff));

   assign sum_in   = {1'b0, total_ff} + (ctcc_pkg::TOTAL_BITS + 1)'(count_ff);
   assign total_in = !hit_ff ? total_ff :
                     sum_in[ctcc_pkg::TOTAL_BITS] ? '1 : sum_in[ctcc_pkg::TOTAL_BITS-1:0];

   // new tag is presented at the head of both chains; only the requesting channel's chain shifts it in
   assign links[0].a_tag = tag_ff;
   assign links[0].a_ok  = 1'b1;
   assign links[0].b_tag = tag_ff;
   assign links[0].b_ok  = 1'b1;
   assign toks[0]        = start_tok_ff;

   assign ctl.clear   = accept && req_first;
   assign ctl.shift_a = (state_ff == FINISH) && out_free && hit_ff && use_a_ff;
   assign ctl.shift_b = (state_ff == FINISH) && out_free && hit_ff && !use_a_ff;

   for (genvar k = 0; k < D; k++) begin : g_cell
      ctcc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .slot_in  (links[k]),
         .slot_out (links[k+1]),
         .ctl      (ctl),
         .probe    (probe_ff),
         .tok_in   (toks[k]),
         .tok_out  (toks[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= IDLE;
         chan_a_ff         <= ctcc_pkg::CHAN_A_RESET;
         chan_b_ff         <= ctcc_pkg::CHAN_B_RESET;
         offset_ff         <= '0;
         window_ff         <= ctcc_pkg::WINDOW_RESET;
         total_ff          <= '0;
         start_tok_ff.live <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               ctcc_pkg::CSR_CHAN_A: chan_a_ff <= csr_wdata[ctcc_pkg::CHAN_BITS-1:0];
               ctcc_pkg::CSR_CHAN_B: chan_b_ff <= csr_wdata[ctcc_pkg::CHAN_BITS-1:0];
               ctcc_pkg::CSR_OFFSET: offset_ff <= csr_wdata;
               ctcc_pkg::CSR_WINDOW: window_ff <= csr_wdata[ctcc_pkg::WINDOW_BITS-1:0];
               default: ;
            endcase
         end

         start_tok_ff.live <= (state_ff == BASE);
         rsp_valid_ff      <= ((state_ff == FINISH) && out_free) ||
                              (rsp_valid_ff && !rsp_tready);

         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  tag_ff   <= req_tag;
                  hit_ff   <= (req_chan <= ctcc_pkg::MAX_CHANNEL) &&
                              ((req_chan == chan_a_ff) || (req_chan == chan_b_ff));
                  use_a_ff <= (req_chan == chan_a_ff);
                  if (req_first) begin
                     total_ff <= '0;
                  end
                  state_ff <= BOUNDS;
               end
            end
            BOUNDS: begin
               lo_ff        <= lo_in;
               hi_ff        <= hi_in;
               reach_ff     <= use_a_ff ? hi_in : -lo_in;
               window_nz_ff <= (window_ff != '0);
               state_ff     <= BASE;
            end
            BASE: begin
               probe_ff.use_a    <= use_a_ff;
               probe_ff.lo_bound <= use_a_ff ? t_ext + lo_wide : t_ext - hi_wide;
               probe_ff.hi_bound <= use_a_ff ? t_ext + hi_wide : t_ext - lo_wide;
               overrun_ff        <= overrun_in;
               state_ff          <= SWEEP;
            end
            SWEEP: begin
               if (toks[D].live) begin
                  count_ff <= hit_ff ? toks[D].count : '0;
                  state_ff <= FINISH;
               end
            end
            FINISH: begin
               if (out_free) begin
                  rsp_matches_ff <= ctcc_pkg::MATCH_BITS'(count_ff);
                  rsp_total_ff   <= total_in;
                  rsp_overrun_ff <= overrun_ff;
                  total_ff       <= total_in;
                  state_ff       <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
      start_tok_ff.count <= '0;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_total_ff, rsp_matches_ff};
   assign rsp_tuser  = rsp_overrun_ff;

endmodule
